// ===== rtl/rth_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rth_pkg
// Shared types and constants of the RGB to HSV converter.
// ----------------------------------------------------------------------------
package rth_pkg;

    typedef logic [1:0] t_sector;

    localparam t_sector SEC_RED   = 2'd0;
    localparam t_sector SEC_GREEN = 2'd1;
    localparam t_sector SEC_BLUE  = 2'd2;

    // extra bits that the hue numerator and six times chroma need over a channel
    localparam int HUE_EXTRA_BITS = 3;

endpackage

`default_nettype wire

// ===== rtl/rth_stream_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rth stream interfaces
// Valid/ready channels carrying one RGB pixel and one HSV pixel per item.
// ----------------------------------------------------------------------------
interface rth_rgb_if #(
    parameter int CHANNEL_BITS = 8
) ();
    logic                    valid;
    logic                    ready;
    logic [CHANNEL_BITS-1:0] red_in;
    logic [CHANNEL_BITS-1:0] green_in;
    logic [CHANNEL_BITS-1:0] blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    output ready);
endinterface

interface rth_hsv_if #(
    parameter int CHANNEL_BITS  = 8,
    parameter int FRACTION_BITS = 16
) ();
    logic                     valid;
    logic                     ready;
    logic [FRACTION_BITS-1:0] hue_out;
    logic [FRACTION_BITS-1:0] saturation_out;
    logic [CHANNEL_BITS-1:0]  value_out;

    modport source (output valid, output hue_out, output saturation_out,
                    output value_out, input ready);
    modport sink   (input valid, input hue_out, input saturation_out,
                    input value_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/rgb_to_hsv_converter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// RGB pixel in, HSV pixel out: hue and saturation as Q0.FRACTION_BITS, value at channel width.
//
//   channel  direction  payload                                   handshake
//   i_rgb    in         red_in, green_in, blue_in                 valid/ready
//   o_hsv    out        hue_out, saturation_out, value_out        valid/ready
//
// One item per cycle sustained while o_hsv is not stalled; the two pipelined
// dividers produce one quotient bit per stage.
// Reset clears the valid bits only; data registers are not reset.
// A stall on o_hsv freezes the whole pipeline; i_rgb.ready falls with it.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter #(
    parameter int CHANNEL_BITS  = 8,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rth_rgb_if.sink    i_rgb,
    rth_hsv_if.source  o_hsv
);
    import rth_pkg::*;

    localparam int CB = CHANNEL_BITS;
    localparam int FB = FRACTION_BITS;
    localparam int HW = CB + HUE_EXTRA_BITS;
    localparam int NW = HW + 1;

    logic w_en;

    // stage 1: input register
    logic          r_s1_vld;
    logic [CB-1:0] r_s1_red, r_s1_green, r_s1_blue;

    // stage 2: max, chroma, sector
    logic          r_s2_vld;
    logic [CB-1:0] r_s2_v, r_s2_c;
    logic [CB:0]   r_s2_diff;
    t_sector       r_s2_sec;
    logic [CB-1:0] n_max, n_min;
    logic [CB:0]   n_diff;
    t_sector       n_sec;

    // stage 3: hue numerator and divisors
    logic          r_s3_vld;
    logic [CB-1:0] r_s3_v, r_s3_c;
    logic [HW-1:0] r_s3_num, r_s3_den;
    logic          r_s3_czero, r_s3_vzero, r_s3_sfull;
    logic [NW-1:0] n_base;
    logic [NW-1:0] n_num_s;
    logic [NW-1:0] n_wrap;
    logic [HW-1:0] n_six;

    // divider sideband
    logic [FB-1:0] r_d_vld;
    logic [CB-1:0] r_d_v     [FB];
    logic          r_d_czero [FB];
    logic          r_d_vzero [FB];
    logic          r_d_sfull [FB];
    logic [FB-1:0] w_hue_quo, w_sat_quo;

    // output register
    logic          r_o_vld;
    logic [FB-1:0] r_o_hue, r_o_sat;
    logic [CB-1:0] r_o_val;

    assign w_en        = !r_o_vld || o_hsv.ready;
    assign i_rgb.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_d_vld  <= '0;
            r_o_vld  <= 1'b0;
        end else if (w_en) begin
            r_s1_vld <= i_rgb.valid;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_d_vld  <= {r_d_vld[FB-2:0], r_s3_vld};
            r_o_vld  <= r_d_vld[FB-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_red   <= i_rgb.red_in;
            r_s1_green <= i_rgb.green_in;
            r_s1_blue  <= i_rgb.blue_in;
        end
    end

    always_comb begin
        n_max = (r_s1_red > r_s1_green) ? r_s1_red : r_s1_green;
        n_max = (n_max > r_s1_blue) ? n_max : r_s1_blue;
        n_min = (r_s1_red < r_s1_green) ? r_s1_red : r_s1_green;
        n_min = (n_min < r_s1_blue) ? n_min : r_s1_blue;
        if (n_max == r_s1_red) begin
            n_sec  = SEC_RED;
            n_diff = {1'b0, r_s1_green} - {1'b0, r_s1_blue};
        end else if (n_max == r_s1_green) begin
            n_sec  = SEC_GREEN;
            n_diff = {1'b0, r_s1_blue} - {1'b0, r_s1_red};
        end else begin
            n_sec  = SEC_BLUE;
            n_diff = {1'b0, r_s1_red} - {1'b0, r_s1_green};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_v    <= n_max;
            r_s2_c    <= n_max - n_min;
            r_s2_diff <= n_diff;
            r_s2_sec  <= n_sec;
        end
    end

    always_comb begin
        case (r_s2_sec)
            SEC_GREEN: n_base = {3'b000, r_s2_c, 1'b0};
            SEC_BLUE:  n_base = {2'b00, r_s2_c, 2'b00};
            default:   n_base = '0;
        endcase
        n_six   = {1'b0, r_s2_c, 2'b00} + {2'b00, r_s2_c, 1'b0};
        n_num_s = n_base + {{HUE_EXTRA_BITS{r_s2_diff[CB]}}, r_s2_diff};
        // wrap negative red sector by one full turn
        n_wrap  = n_num_s[NW-1] ? (n_num_s + {1'b0, n_six}) : n_num_s;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_v     <= r_s2_v;
            r_s3_c     <= r_s2_c;
            r_s3_num   <= n_wrap[HW-1:0];
            r_s3_den   <= n_six;
            r_s3_czero <= (r_s2_c == '0);
            r_s3_vzero <= (r_s2_v == '0);
            r_s3_sfull <= (r_s2_c == r_s2_v);
        end
    end

    rth_divider #(
        .DW (HW),
        .QW (FB)
    ) u_hue_div (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_s3_num),
        .i_den (r_s3_den),
        .o_quo (w_hue_quo)
    );

    rth_divider #(
        .DW (CB),
        .QW (FB)
    ) u_sat_div (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_s3_c),
        .i_den (r_s3_v),
        .o_quo (w_sat_quo)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_v[0]     <= r_s3_v;
            r_d_czero[0] <= r_s3_czero;
            r_d_vzero[0] <= r_s3_vzero;
            r_d_sfull[0] <= r_s3_sfull;
            for (int k = 1; k < FB; k++) begin
                r_d_v[k]     <= r_d_v[k-1];
                r_d_czero[k] <= r_d_czero[k-1];
                r_d_vzero[k] <= r_d_vzero[k-1];
                r_d_sfull[k] <= r_d_sfull[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_val <= r_d_v[FB-1];
            r_o_hue <= r_d_czero[FB-1] ? '0 : w_hue_quo;
            if (r_d_vzero[FB-1]) begin
                r_o_sat <= '0;
            end else if (r_d_sfull[FB-1]) begin
                r_o_sat <= '1;
            end else begin
                r_o_sat <= w_sat_quo;
            end
        end
    end

    assign o_hsv.valid          = r_o_vld;
    assign o_hsv.hue_out        = r_o_hue;
    assign o_hsv.saturation_out = r_o_sat;
    assign o_hsv.value_out      = r_o_val;

`ifndef NO_ASSERTIONS
    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_d_vld) && $stable(r_s3_num) && $stable(r_s1_vld))
        else $error("pipeline moved during a stall");

    a_black_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hsv.valid && (o_hsv.value_out == '0) |->
            (o_hsv.saturation_out == '0) && (o_hsv.hue_out == '0))
        else $error("black pixel with nonzero hue or saturation");

    a_gray_hue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hsv.valid && (o_hsv.saturation_out == '0) |-> (o_hsv.hue_out == '0))
        else $error("zero saturation with nonzero hue");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_hsv.valid && (r_d_vld == '0))
        else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire

// ===== rtl/rth_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rth_divider
// Pipelined restoring divider, one quotient bit per stage. Gives
// floor(num * 2^QW / den) for num < den; the QW stages advance only on i_en.
// ----------------------------------------------------------------------------
module rth_divider #(
    parameter int DW = 11,
    parameter int QW = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [DW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic      [QW-1:0] o_quo
);

    logic [DW-1:0] r_rem [QW-1];
    logic [DW-1:0] r_den [QW-1];
    logic [QW-1:0] r_quo [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW-1:0] w_rem_in;
        logic [DW-1:0] w_den_in;
        logic [QW-1:0] w_quo_in;
        logic [DW:0]   w_shift;
        logic          w_bit;

        if (k == 0) begin : g_first
            assign w_rem_in = i_num;
            assign w_den_in = i_den;
            assign w_quo_in = '0;
        end else begin : g_next
            assign w_rem_in = r_rem[k-1];
            assign w_den_in = r_den[k-1];
            assign w_quo_in = r_quo[k-1];
        end

        assign w_shift = {w_rem_in, 1'b0};
        assign w_bit   = (w_shift >= {1'b0, w_den_in});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[k] <= {w_quo_in[QW-2:0], w_bit};
            end
        end

        if (k < QW - 1) begin : g_carry
            logic [DW:0] w_diff;

            assign w_diff = w_shift - {1'b0, w_den_in};

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= w_bit ? w_diff[DW-1:0] : w_shift[DW-1:0];
                    r_den[k] <= w_den_in;
                end
            end
        end
    end

    assign o_quo = r_quo[QW-1];

endmodule

`default_nettype wire
